>>> design/dncal_pkg.sv
// Shared types and constants for the day number to calendar parts converter.
package dncal_pkg;

	localparam int DN_W    = 22;
	localparam int YEAR_W  = 14;
	localparam int ORD_W   = 9;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int WD_W    = 3;
	localparam int WEEK_W  = 6;

	// Register stages from input to output register
	localparam int NSTG = 10;

	// Cycle lengths in days
	localparam logic [17:0] DAYS_400 = 18'd146097;
	localparam logic [15:0] DAYS_100 = 16'd36524;
	localparam logic [10:0] DAYS_4   = 11'd1461;
	localparam logic [8:0]  DAYS_1   = 9'd365;

	// Reciprocals: floor(x * RECIP >> SH) is the quotient or one below it
	localparam logic [12:0] RECIP_400 = 13'd7349;
	localparam int          SH_400    = 30;
	localparam logic [10:0] RECIP_4   = 11'd1435;
	localparam int          SH_4      = 21;
	localparam logic [8:0]  RECIP_7   = 9'd293;
	localparam int          SH_7      = 11;

	// First ordinal day of each month in a common year
	localparam logic [8:0] MONTH_START [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	// Weekday codes used by the ISO week rule
	localparam logic [WD_W-1:0] WD_THURSDAY = 3'd3;
	localparam logic [WD_W-1:0] WD_FRIDAY   = 3'd4;

	typedef struct packed {
		logic              ok;
		logic [WD_W-1:0]   wd;
		logic [1:0]        cent;
		logic [YEAR_W-1:0] ybase;
		logic [15:0]       rem100;
	} era_t;

	typedef struct packed {
		logic              ok;
		logic [WD_W-1:0]   wd;
		logic [ORD_W-1:0]  ord;
		logic [YEAR_W-1:0] year;
		logic              leap;
		logic              leap_prev;
	} yr_t;

	typedef struct packed {
		logic               valid_res;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day_of_month;
		logic [ORD_W-1:0]   day_of_year;
		logic [WD_W-1:0]    weekday;
		logic [WEEK_W-1:0]  iso_week;
		logic [YEAR_W-1:0]  iso_week_year;
	} res_t;

endpackage

>>> design/dncal_era.sv
// Stages 1 to 4: weekday, 400-year and 100-year split of the day number.
module dncal_era (
	input  logic                             clk,
	input  logic [4:1]                       ld,
	input  logic [dncal_pkg::DN_W-1:0]       day_number,
	input  logic                             ok,
	output dncal_pkg::era_t                  era
);

	// Stage 1 signals
	logic [23:0]                  dn_ext;
	logic [34:0]                  m1;
	logic [5:0]                   oct_sum;
	logic [3:0]                   fold;
	logic [3:0]                   fold2;
	logic [dncal_pkg::WD_W-1:0]   wd_c;
	logic [dncal_pkg::DN_W-1:0]   dn_s1;
	logic [4:0]                   qa_s1;
	logic [dncal_pkg::WD_W-1:0]   wd_s1;
	logic                         ok_s1;

	// Stage 2
	logic [dncal_pkg::DN_W-1:0]   dn_s2;
	logic [22:0]                  p_s2;
	logic [4:0]                   qa_s2;
	logic [dncal_pkg::WD_W-1:0]   wd_s2;
	logic                         ok_s2;

	// Stage 3
	logic [22:0]                  diff3;
	logic                         fix3;
	logic [4:0]                   q400_s3;
	logic [17:0]                  r400_s3;
	logic [dncal_pkg::WD_W-1:0]   wd_s3;
	logic                         ok_s3;

	// Stage 4
	logic [1:0]                   cent_c;
	logic [15:0]                  rem_c;
	logic [17:0]                  csub;
	logic [dncal_pkg::YEAR_W-1:0] ybase_c;

	// Day number mod 7: eight is one mod seven, so sum the octal digits and fold
	always_comb begin
		dn_ext  = {2'b00, day_number};
		oct_sum = '0;
		for (int i = 0; i < 8; i++) begin
			oct_sum = oct_sum + 6'(dn_ext[3*i +: 3]);
		end
		fold  = 4'(oct_sum[5:3]) + 4'(oct_sum[2:0]);
		fold2 = (fold >= 4'd7) ? fold - 4'd7 : fold;
		wd_c  = (fold2 == 4'd7) ? 3'd0 : fold2[2:0];
	end

	assign m1 = 35'(day_number) * 35'(dncal_pkg::RECIP_400);

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			dn_s1 <= day_number;
			qa_s1 <= m1[dncal_pkg::SH_400 +: 5];
			wd_s1 <= wd_c;
			ok_s1 <= ok;
		end
		if (ld[2]) begin
			dn_s2 <= dn_s1;
			p_s2  <= 23'(qa_s1) * 23'(dncal_pkg::DAYS_400);
			qa_s2 <= qa_s1;
			wd_s2 <= wd_s1;
			ok_s2 <= ok_s1;
		end
		if (ld[3]) begin
			q400_s3 <= qa_s2 + 5'(fix3);
			r400_s3 <= fix3 ? 18'(diff3 - 23'(dncal_pkg::DAYS_400)) : 18'(diff3);
			wd_s3   <= wd_s2;
			ok_s3   <= ok_s2;
		end
		if (ld[4]) begin
			era.ok     <= ok_s3;
			era.wd     <= wd_s3;
			era.cent   <= cent_c;
			era.ybase  <= ybase_c;
			era.rem100 <= rem_c;
		end
	end

	// Correct the reciprocal estimate by one at most
	assign diff3 = 23'(dn_s2) - p_s2;
	assign fix3  = diff3 >= 23'(dncal_pkg::DAYS_400);

	always_comb begin
		csub = '0;
		if (r400_s3 == 18'(dncal_pkg::DAYS_400 - 18'd1)) begin
			// last day of a 400-year cycle: leap day of the fourth century
			cent_c = 2'd3;
			rem_c  = dncal_pkg::DAYS_100;
		end else begin
			cent_c = 2'(r400_s3 >= 18'(dncal_pkg::DAYS_100))
				+ 2'(r400_s3 >= 18'(dncal_pkg::DAYS_100) * 18'd2)
				+ 2'(r400_s3 >= 18'(dncal_pkg::DAYS_100) * 18'd3);
			csub   = 18'(cent_c) * 18'(dncal_pkg::DAYS_100);
			rem_c  = 16'(r400_s3 - csub);
		end
		ybase_c = 14'd1 + 14'(q400_s3) * 14'd400 + 14'(cent_c) * 14'd100;
	end

endmodule

>>> design/dncal_year.sv
// Stages 5 to 8: 4-year and 1-year split, day of year, year and leap flags.
module dncal_year (
	input  logic            clk,
	input  logic [8:5]      ld,
	input  dncal_pkg::era_t era,
	output dncal_pkg::yr_t  yr
);

	logic [26:0]        m5;
	dncal_pkg::era_t    e_s5;
	logic [4:0]         qa_s5;

	dncal_pkg::era_t    e_s6;
	logic [15:0]        p_s6;
	logic [4:0]         qa_s6;

	logic [15:0]        diff7;
	logic               fix7;
	dncal_pkg::era_t    e_s7;
	logic [4:0]         q4_s7;
	logic [10:0]        r4_s7;

	logic [1:0]         c1;
	logic [10:0]        ysub;
	logic [dncal_pkg::ORD_W-1:0] ord_c;

	assign m5 = 27'(era.rem100) * 27'(dncal_pkg::RECIP_4);

	assign diff7 = e_s6.rem100 - p_s6;
	assign fix7  = diff7 >= 16'(dncal_pkg::DAYS_4);

	always_comb begin
		if (r4_s7 == dncal_pkg::DAYS_4 - 11'd1) begin
			// last day of a 4-year block is the leap day of its fourth year
			c1    = 2'd3;
			ysub  = '0;
			ord_c = dncal_pkg::DAYS_1;
		end else begin
			c1    = 2'(r4_s7 >= 11'(dncal_pkg::DAYS_1))
				+ 2'(r4_s7 >= 11'(dncal_pkg::DAYS_1) * 11'd2)
				+ 2'(r4_s7 >= 11'(dncal_pkg::DAYS_1) * 11'd3);
			ysub  = 11'(c1) * 11'(dncal_pkg::DAYS_1);
			ord_c = 9'(r4_s7 - ysub);
		end
	end

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			e_s5  <= era;
			qa_s5 <= m5[dncal_pkg::SH_4 +: 5];
		end
		if (ld[6]) begin
			e_s6  <= e_s5;
			p_s6  <= 16'(qa_s5) * 16'(dncal_pkg::DAYS_4);
			qa_s6 <= qa_s5;
		end
		if (ld[7]) begin
			e_s7  <= e_s6;
			q4_s7 <= qa_s6 + 5'(fix7);
			r4_s7 <= fix7 ? 11'(diff7 - 16'(dncal_pkg::DAYS_4)) : 11'(diff7);
		end
		if (ld[8]) begin
			yr.ok   <= e_s7.ok;
			yr.wd   <= e_s7.wd;
			yr.ord  <= ord_c;
			yr.year <= e_s7.ybase + {q4_s7, 2'b00} + 14'(c1);
			// leap: fourth year of the block, not a century unless the fourth one
			yr.leap <= (c1 == 2'd3) && ((q4_s7 != 5'd24) || (e_s7.cent == 2'd3));
			// year before leap: first year of the block, not at a century start unless in the first century
			yr.leap_prev <= (c1 == 2'd0) && ((q4_s7 != 5'd0) || (e_s7.cent == 2'd0));
		end
	end

endmodule

>>> design/dncal_week.sv
// Stages 9 and 10: month and day of month, ISO week and week-numbering year.
module dncal_week (
	input  logic             clk,
	input  logic [10:9]      ld,
	input  dncal_pkg::yr_t   yr,
	output dncal_pkg::res_t  res
);

	logic [dncal_pkg::ORD_W-1:0]   r;
	logic [dncal_pkg::ORD_W-1:0]   st;
	logic [dncal_pkg::MONTH_W-1:0] mon_c;
	logic [dncal_pkg::DAY_W-1:0]   day_c;
	logic [9:0]                    thu_sum;
	logic [dncal_pkg::ORD_W-1:0]   thu_c;
	logic                          prev_c;
	logic                          next_c;

	dncal_pkg::yr_t                y_s9;
	logic [dncal_pkg::MONTH_W-1:0] mon_s9;
	logic [dncal_pkg::DAY_W-1:0]   day_s9;
	logic [dncal_pkg::ORD_W-1:0]   thu_s9;
	logic                          prev_s9;
	logic                          next_s9;
	logic [dncal_pkg::WD_W-1:0]    dec31_s9;

	logic [17:0]                   m10;
	logic [dncal_pkg::WEEK_W-1:0]  week_c;
	logic [dncal_pkg::YEAR_W-1:0]  wyear_c;

	always_comb begin
		r     = yr.ord;
		st    = '0;
		mon_c = '0;
		if (yr.ord < 9'd31) begin
			mon_c = 4'd0;
			st    = 9'd0;
		end else if (yr.ord < 9'd59 || (yr.leap && yr.ord == 9'd59)) begin
			mon_c = 4'd1;
			st    = 9'd31;
		end else begin
			// drop the leap day, then find the last month start not above
			r = yr.leap ? yr.ord - 9'd1 : yr.ord;
			for (int m = 2; m < 12; m++) begin
				if (r >= dncal_pkg::MONTH_START[m]) begin
					mon_c = 4'(m);
					st    = dncal_pkg::MONTH_START[m];
				end
			end
		end
		day_c = 5'(r - st);

		thu_sum = 10'(yr.ord) + 10'd3;
		prev_c  = thu_sum < 10'(yr.wd);
		thu_c   = 9'(thu_sum - 10'(yr.wd));
		next_c  = !prev_c && (thu_c >= 9'd365) && ((thu_c >= 9'd366) || !yr.leap);
	end

	assign m10 = 18'(thu_s9) * 18'(dncal_pkg::RECIP_7);

	always_comb begin
		if (prev_s9) begin
			wyear_c = y_s9.year - 14'd1;
			week_c  = ((dec31_s9 == dncal_pkg::WD_THURSDAY)
				|| (dec31_s9 == dncal_pkg::WD_FRIDAY && y_s9.leap_prev)) ? 6'd52 : 6'd51;
		end else if (next_s9) begin
			wyear_c = y_s9.year + 14'd1;
			week_c  = '0;
		end else begin
			wyear_c = y_s9.year;
			week_c  = m10[dncal_pkg::SH_7 +: dncal_pkg::WEEK_W];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[9]) begin
			y_s9    <= yr;
			mon_s9  <= mon_c;
			day_s9  <= day_c;
			thu_s9  <= thu_c;
			prev_s9 <= prev_c;
			next_s9 <= next_c;
			// only used in early January, where day of year is the day of month
			dec31_s9 <= 3'(yr.wd - 3'(yr.ord) - 3'd1);
		end
		if (ld[10]) begin
			if (y_s9.ok) begin
				res.valid_res     <= 1'b1;
				res.year          <= y_s9.year;
				res.month         <= mon_s9;
				res.day_of_month  <= day_s9;
				res.day_of_year   <= y_s9.ord;
				res.weekday       <= y_s9.wd;
				res.iso_week      <= week_c;
				res.iso_week_year <= wyear_c;
			end else begin
				res <= '0;
			end
		end
	end

endmodule

>>> design/day_number_to_calendar_parts.sv
// Top level: handshake and valid pipeline of the day number converter.
// Converts a day number (0 is Monday, January 1 of year 1) to year, month,
// day, day of year and weekday and ISO week. Ten register stages: a word
// accepted at the input passes through every stage to the output, and one
// word can enter every cycle unless a stalled output has backed up the
// pipeline. The 400- and 4-year splits each take three stages (reciprocal
// multiply, product, correct-by-one subtract) and set the depth. A stage loads
// whenever it or any stage after it holds a bubble, so a stalled output
// backs up the pipeline one stage at a time and in_stall rises only when
// all ten stages hold words.
module day_number_to_calendar_parts #(
	parameter int unsigned MAX_DAY_NUMBER = 3652058
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [21:0] day_number,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        valid_res,
	output logic [13:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month,
	output logic [8:0]  day_of_year,
	output logic [2:0]  weekday,
	output logic [5:0]  iso_week,
	output logic [13:0] iso_week_year
);

	logic [dncal_pkg::NSTG:1] vld_q;
	logic [dncal_pkg::NSTG:1] ld;
	logic                     ok;
	dncal_pkg::era_t          era;
	dncal_pkg::yr_t           yr;
	dncal_pkg::res_t          res;

	// A stage may load when it is empty or the stage after it loads
	always_comb begin
		ld[dncal_pkg::NSTG] = !vld_q[dncal_pkg::NSTG] || !out_stall;
		for (int k = dncal_pkg::NSTG - 1; k >= 1; k--) begin
			ld[k] = !vld_q[k] || ld[k+1];
		end
	end

	assign in_stall = !ld[1];
	assign ok       = day_number <= dncal_pkg::DN_W'(MAX_DAY_NUMBER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= dncal_pkg::NSTG; k++) begin
				if (ld[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	dncal_era u_era (
		.clk        (clk),
		.ld         (ld[4:1]),
		.day_number (day_number),
		.ok         (ok),
		.era        (era)
	);

	dncal_year u_year (
		.clk (clk),
		.ld  (ld[8:5]),
		.era (era),
		.yr  (yr)
	);

	dncal_week u_week (
		.clk (clk),
		.ld  (ld[10:9]),
		.yr  (yr),
		.res (res)
	);

	assign out_valid     = vld_q[dncal_pkg::NSTG];
	assign valid_res     = res.valid_res;
	assign year          = res.year;
	assign month         = res.month;
	assign day_of_month  = res.day_of_month;
	assign day_of_year   = res.day_of_year;
	assign weekday       = res.weekday;
	assign iso_week      = res.iso_week;
	assign iso_week_year = res.iso_week_year;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the day number to calendar parts converter.
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned MAX_DN     = 3652058;
	localparam int unsigned DN_TOP     = 4194303;
	localparam int unsigned CYCLE_CAP  = 400000;
	localparam int unsigned HOLD_LEN   = 80;
	localparam int unsigned SETTLE_CYC = 2 * dncal_pkg::NSTG + 4;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [dncal_pkg::DN_W-1:0]   day_number = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic                         valid_res;
	logic [dncal_pkg::YEAR_W-1:0] year;
	logic [3:0]                   month;
	logic [4:0]                   day_of_month;
	logic [8:0]                   day_of_year;
	logic [2:0]                   weekday;
	logic [5:0]                   iso_week;
	logic [dncal_pkg::YEAR_W-1:0] iso_week_year;

	day_number_to_calendar_parts #(
		.MAX_DAY_NUMBER(MAX_DN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.day_number(day_number),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.valid_res(valid_res),
		.year(year),
		.month(month),
		.day_of_month(day_of_month),
		.day_of_year(day_of_year),
		.weekday(weekday),
		.iso_week(iso_week),
		.iso_week_year(iso_week_year)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	dncal_pkg::res_t pending_dates[$];
	int unsigned     mismatches = 0;
	int unsigned     orphans = 0;
	int unsigned     words_sent = 0;
	int unsigned     words_checked = 0;
	int unsigned     n_out_of_range = 0;
	int unsigned     n_prev_year_week = 0;
	int unsigned     n_next_year_week = 0;
	int unsigned     cycles = 0;
	bit              no_idle = 1'b0;
	bit              hold_off_req = 1'b0;
	int unsigned     hold_off_left = 0;

	function automatic bit is_leap(input int unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	// Expected calendar parts of one day number
	function automatic dncal_pkg::res_t calendar_of_day(input logic [dncal_pkg::DN_W-1:0] dn_in);
		dncal_pkg::res_t r;
		int unsigned     dn, yr, rem, wd, mon, dom, wyr, wk, adj, dec31;
		int              thu;
		bit              lp;
		r = '0;
		dn = dn_in;
		if (dn > MAX_DN)
			return r;
		yr = 1 + 400 * (dn / 146097);
		rem = dn % 146097;
		if (rem == 146096) begin
			yr += 300;
			rem = 36524;
		end else begin
			yr += 100 * (rem / 36524);
			rem = rem % 36524;
		end
		yr += 4 * (rem / 1461);
		rem = rem % 1461;
		if (rem == 1460) begin
			yr += 3;
			rem = 365;
		end else begin
			yr += rem / 365;
			rem = rem % 365;
		end
		wd = dn % 7;
		lp = is_leap(yr);
		if (rem < 31) begin
			mon = 0;
			dom = rem;
		end else if (rem < 59 || (lp && rem == 59)) begin
			mon = 1;
			dom = rem - 31;
		end else begin
			adj = lp ? rem - 1 : rem;
			mon = 11;
			while (mon > 2 && adj < dncal_pkg::MONTH_START[mon])
				mon--;
			dom = adj - dncal_pkg::MONTH_START[mon];
		end
		thu = int'(rem) + 3 - int'(wd);
		if (thu < 0) begin
			// nearest Thursday is in the previous year: step back to its Dec 31
			wyr = yr - 1;
			dec31 = (wd + 14 - (dom % 7) - 1) % 7;
			wk = (dec31 == dncal_pkg::WD_THURSDAY
				|| (dec31 == dncal_pkg::WD_FRIDAY && is_leap(wyr))) ? 52 : 51;
		end else if (thu >= 365 && (thu >= 366 || !lp)) begin
			wyr = yr + 1;
			wk = 0;
		end else begin
			wyr = yr;
			wk = thu / 7;
		end
		r.valid_res     = 1'b1;
		r.year          = yr[dncal_pkg::YEAR_W-1:0];
		r.month         = mon[dncal_pkg::MONTH_W-1:0];
		r.day_of_month  = dom[dncal_pkg::DAY_W-1:0];
		r.day_of_year   = rem[dncal_pkg::ORD_W-1:0];
		r.weekday       = wd[dncal_pkg::WD_W-1:0];
		r.iso_week      = wk[dncal_pkg::WEEK_W-1:0];
		r.iso_week_year = wyr[dncal_pkg::YEAR_W-1:0];
		return r;
	endfunction

	// Offer one word, hold it until accepted, then maybe idle
	task automatic send_day(input int unsigned dn);
		dncal_pkg::res_t exp_r;
		@(negedge clk);
		in_valid <= 1'b1;
		day_number <= dn[dncal_pkg::DN_W-1:0];
		do
			@(posedge clk);
		while (in_stall);
		exp_r = calendar_of_day(dn[dncal_pkg::DN_W-1:0]);
		pending_dates.push_back(exp_r);
		words_sent++;
		if (!exp_r.valid_res)
			n_out_of_range++;
		else if (exp_r.iso_week_year < exp_r.year)
			n_prev_year_week++;
		else if (exp_r.iso_week_year > exp_r.year)
			n_next_year_week++;
		if (!no_idle && $urandom_range(0, 99) < 37) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_dates.size() == 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Receiver: random stalls, quiet stretches and a requested long hold-off
	always @(negedge clk) begin
		if (hold_off_left != 0) begin
			out_stall <= 1'b1;
			hold_off_left--;
		end else if (hold_off_req) begin
			hold_off_req = 1'b0;
			hold_off_left = HOLD_LEN - 1;
			out_stall <= 1'b1;
		end else if (no_idle || !arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 37);
		end
	end

	task automatic check_field(input string fname, input int unsigned exp_v,
			input int unsigned got_v, inout bit bad);
		if (exp_v != got_v) begin
			if (mismatches < 10)
				$display("  %s: expected %0d, got %0d", fname, exp_v, got_v);
			bad = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		dncal_pkg::res_t exp_r;
		bit              bad;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_dates.size() == 0) begin
				orphans++;
				if (orphans + mismatches <= 10)
					$display("unexpected result word at cycle %0d", cycles);
			end else begin
				exp_r = pending_dates.pop_front();
				bad = 1'b0;
				if (mismatches < 10 && exp_r != {valid_res, year, month, day_of_month,
						day_of_year, weekday, iso_week, iso_week_year})
					$display("mismatch on word %0d at cycle %0d:", words_checked, cycles);
				check_field("valid_res", exp_r.valid_res, valid_res, bad);
				check_field("year", exp_r.year, year, bad);
				check_field("month", exp_r.month, month, bad);
				check_field("day_of_month", exp_r.day_of_month, day_of_month, bad);
				check_field("day_of_year", exp_r.day_of_year, day_of_year, bad);
				check_field("weekday", exp_r.weekday, weekday, bad);
				check_field("iso_week", exp_r.iso_week, iso_week, bad);
				check_field("iso_week_year", exp_r.iso_week_year, iso_week_year, bad);
				if (bad)
					mismatches++;
				words_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, pending_dates.size());
			$display("day_number_to_calendar_parts test failed");
			$finish;
		end
	end

	// Range ends, cycle ends, leap day and ISO week wrap cases
	task automatic test_directed();
		int unsigned picks[$];
		picks = '{0, 6, 364, 365, 1154, 1460, 1461, 1826, 3287, 36523, 36524,
			146095, 146096, 146097, 1398101, 2796202, MAX_DN - 3, MAX_DN,
			MAX_DN + 1, DN_TOP - 1, DN_TOP};
		foreach (picks[i])
			send_day(picks[i]);
	endtask

	// Uniform over the whole input range, mostly valid
	task automatic test_uniform(input int unsigned count);
		repeat (count) begin
			if ($urandom_range(0, 99) < 85)
				send_day($urandom_range(0, MAX_DN));
			else
				send_day($urandom & DN_TOP);
		end
	endtask

	// Days within a week of a random January 1
	task automatic test_year_edges(input int unsigned count);
		int              dn;
		dncal_pkg::res_t r;
		repeat (count) begin
			dn = $urandom_range(0, MAX_DN);
			r = calendar_of_day(dn[dncal_pkg::DN_W-1:0]);
			dn = dn - int'(r.day_of_year) + int'($urandom_range(0, 14)) - 7;
			if (dn < 0)
				dn = 0;
			send_day(dn);
		end
	endtask

	// Days around the ends of 400-, 100- and 4-year cycles
	task automatic test_cycle_edges(input int unsigned count);
		int dn;
		repeat (count) begin
			dn = 146097 * $urandom_range(0, 24);
			case ($urandom_range(0, 2))
				0: dn += 146096;
				1: dn += 36524 * $urandom_range(1, 3);
				default: dn += 36524 * $urandom_range(0, 3) + 1461 * $urandom_range(1, 24);
			endcase
			dn += int'($urandom_range(0, 4)) - 2;
			if (dn < 0)
				dn = 0;
			send_day(dn);
		end
	endtask

	task automatic test_out_of_range(input int unsigned count);
		repeat (count)
			send_day($urandom_range(MAX_DN + 1, DN_TOP));
	endtask

	// Hold the output off while the sender keeps offering, to fill the pipe
	task automatic test_backpressure();
		no_idle = 1'b1;
		hold_off_req = 1'b1;
		repeat (40)
			send_day($urandom_range(0, MAX_DN));
		no_idle = 1'b0;
	endtask

	task automatic test_no_idle(input int unsigned count);
		no_idle = 1'b1;
		test_uniform(count);
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_uniform(300);
		test_year_edges(150);
		wait_drained();
		test_backpressure();
		test_cycle_edges(60);
		test_no_idle(120);
		test_out_of_range(50);
		wait_drained();
		test_year_edges(120);
		test_uniform(200);
		@(negedge clk);
		in_valid <= 1'b0;
		wait_drained();
		$display("sent %0d words, checked %0d: %0d out of range, %0d weeks of prior year,",
			words_sent, words_checked, n_out_of_range, n_prev_year_week);
		$display("%0d weeks of next year, with random stalls, a long hold-off and drains",
			n_next_year_week);
		if (mismatches == 0 && orphans == 0 && pending_dates.size() == 0) begin
			$display("day_number_to_calendar_parts test passed");
		end else begin
			$display("%0d mismatches, %0d unexpected, %0d missing",
				mismatches, orphans, pending_dates.size());
			$display("day_number_to_calendar_parts test failed");
		end
		$finish;
	end

endmodule
